>>> sv/dq_current_controller_inverse_park_defines.svh
// assertion macros for the dq current controller
`ifndef DQ_CURRENT_CONTROLLER_INVERSE_PARK_DEFINES_SVH
`define DQ_CURRENT_CONTROLLER_INVERSE_PARK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DQIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DQIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dqip_pkg.sv
// constants, tables and helpers of the dq current controller
package dqip_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int SIG_FRAC     = 16;
    localparam int COEF_FRAC    = 22;
    localparam int TRIG_FRAC    = 30;
    localparam int GAIN_FRAC    = 32;

    // serial multiplier: operand width and accumulator width
    localparam int MUL_BITS     = 36;
    localparam int ACC_W        = 72;

    localparam int CORDIC_STEPS = 24;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 33;
    localparam int PH_W         = 34;

    // duty division: quotient bits and remainder width
    localparam int QUOT_BITS    = 18;
    localparam int REM_W        = 51;
    localparam int DIV_DONE     = QUOT_BITS + 1;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic signed [MUL_BITS-1:0] GAIN_Q32    = 36'sd93428374;
    localparam logic signed [MUL_BITS-1:0] INV_TWO_PI  = 36'sd683565276;
    localparam logic signed [MUL_BITS-1:0] HALF_SQRT3  = 36'sd929887697;
    localparam logic signed [CX_W-1:0]     CORDIC_GAIN = 34'sd652032874;
    localparam logic [REM_W-1:0]           DUTY_DIV    = REM_W'(100) << SIG_FRAC;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd7;

    // cordic arctangent table in 2^-32 turns
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // shift right rounding half up
    function automatic logic signed [ACC_W-1:0] round_shr(input logic signed [ACC_W-1:0] v,
                                                         input int s);
        logic signed [ACC_W-1:0] half;
        half = 72'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

endpackage

>>> sv/dq_current_controller_inverse_park.sv
// dq current controller: sample scaling, two biquads, inverse park and clarke, duties
//
//   channel   direction   handshake                 payload
//   input     in          i_in_valid / o_in_stall   i_raw_direct, i_raw_quadrature, i_raw_angle
//   output    out         o_out_valid / i_out_stall o_duty_phase_a, _b, _c
//   config    in          i_cfg_we                  i_cfg_addr, i_cfg_data
//
// from acceptance to the output register, one word goes through 22 products on a
// bit-serial multiplier, the cordic rotations, three serial divides, 9 rounding steps
// and one handover step
// one word in flight; the input is stalled until the result is moved to the output register,
// so a new word is accepted only once the last one has been handed over
// a full output register holds the finished result back while the output is stalled
// synchronous reset clears control state and filter history and loads the default configuration
`include "dq_current_controller_inverse_park_defines.svh"

module dq_current_controller_inverse_park (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [dqip_pkg::SAMPLE_BITS-1:0]      i_raw_direct,
    input  logic [dqip_pkg::SAMPLE_BITS-1:0]      i_raw_quadrature,
    input  logic [dqip_pkg::SAMPLE_BITS-1:0]      i_raw_angle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [15:0]                    o_duty_phase_a,
    output logic signed [15:0]                    o_duty_phase_b,
    output logic signed [15:0]                    o_duty_phase_c,
    input  logic                                  i_cfg_we,
    input  logic [dqip_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [dqip_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_state;

    typedef enum logic [5:0] {
        P_MUL_ID, P_ID, P_MUL_IQ, P_IQ, P_MUL_RHO, P_RHO,
        P_MUL_DB0, P_MUL_DB1, P_MUL_DB2, P_MUL_DA1, P_MUL_DA2, P_YD,
        P_MUL_QB0, P_MUL_QB1, P_MUL_QB2, P_MUL_QA1, P_MUL_QA2, P_YQ,
        P_MUL_TURN, P_TURN, P_CORDIC,
        P_MUL_AC, P_MUL_AS, P_ALPHA, P_MUL_BS, P_MUL_BC, P_BETA,
        P_MUL_ROOT, P_ROOT,
        P_MUL_PA, P_DIV_A, P_MUL_PB, P_DIV_B, P_MUL_PC, P_DIV_C
    } t_step;

    localparam int AW = dqip_pkg::ACC_W;

    // configuration registers
    logic signed [23:0] r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic signed [15:0] r_ref;
    logic [15:0]        r_offset, r_period;

    // sequencer
    t_state      r_state;
    t_step       r_pc;
    logic [5:0]  r_cnt;

    // latched samples and signals
    logic [dqip_pkg::SAMPLE_BITS-1:0] r_raw_d, r_raw_q, r_raw_a;
    logic signed [31:0] r_id, r_iq, r_rho, r_ed, r_eq, r_yd, r_yq, r_alpha, r_beta;
    logic signed [31:0] r_deh0, r_deh1, r_doh0, r_doh1;
    logic signed [31:0] r_qeh0, r_qeh1, r_qoh0, r_qoh1;
    logic signed [dqip_pkg::PH_W-1:0] r_phb, r_phc;

    // serial multiplier
    logic signed [AW-1:0]               r_acc, r_ma;
    logic signed [dqip_pkg::MUL_BITS-1:0] r_mb;

    // cordic
    logic signed [dqip_pkg::CX_W-1:0] r_cx, r_cy;
    logic signed [dqip_pkg::CZ_W-1:0] r_cz;
    logic                             r_flip;

    // serial divide
    logic [dqip_pkg::REM_W-1:0]     r_rem, r_dd;
    logic [dqip_pkg::QUOT_BITS-1:0] r_q;
    logic                           r_dneg, r_dovf;

    // results
    logic signed [15:0] r_duty_a, r_duty_b, r_duty_c;
    logic               r_out_valid;
    logic signed [15:0] r_out_a, r_out_b, r_out_c;

    // combinational helpers
    logic signed [dqip_pkg::MUL_BITS-1:0] mul_a, mul_b;
    logic                                 mul_sub;
    logic signed [AW-1:0]                 n_acc;
    logic signed [dqip_pkg::CX_W-1:0]     n_cx, n_cy, dx, dy;
    logic signed [dqip_pkg::CZ_W-1:0]     n_cz;
    logic [4:0]                           cidx;
    logic [31:0]                          turn, turn_q, turn_z;
    logic                                 turn_flip;
    logic signed [AW-1:0]                 half, mag;
    logic [dqip_pkg::REM_W:0]             trial;
    logic                                 div_ge;
    logic signed [15:0]                   n_duty;
    logic signed [31:0]                   n_y;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_duty_phase_a = r_out_a;
    assign o_duty_phase_b = r_out_b;
    assign o_duty_phase_c = r_out_c;

    // multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
        case (r_pc)
            P_MUL_ID:   begin mul_a = dqip_pkg::GAIN_Q32; mul_b = 36'(r_raw_d); end
            P_MUL_IQ:   begin mul_a = dqip_pkg::GAIN_Q32; mul_b = 36'(r_raw_q); end
            P_MUL_RHO:  begin mul_a = dqip_pkg::GAIN_Q32; mul_b = 36'(r_raw_a); end
            P_MUL_DB0:  begin mul_a = 36'(r_coef_b0); mul_b = 36'(r_ed); end
            P_MUL_DB1:  begin mul_a = 36'(r_coef_b1); mul_b = 36'(r_deh0); end
            P_MUL_DB2:  begin mul_a = 36'(r_coef_b2); mul_b = 36'(r_deh1); end
            P_MUL_DA1:  begin mul_a = 36'(r_coef_a1); mul_b = 36'(r_doh0); mul_sub = 1'b1; end
            P_MUL_DA2:  begin mul_a = 36'(r_coef_a2); mul_b = 36'(r_doh1); mul_sub = 1'b1; end
            P_MUL_QB0:  begin mul_a = 36'(r_coef_b0); mul_b = 36'(r_eq); end
            P_MUL_QB1:  begin mul_a = 36'(r_coef_b1); mul_b = 36'(r_qeh0); end
            P_MUL_QB2:  begin mul_a = 36'(r_coef_b2); mul_b = 36'(r_qeh1); end
            P_MUL_QA1:  begin mul_a = 36'(r_coef_a1); mul_b = 36'(r_qoh0); mul_sub = 1'b1; end
            P_MUL_QA2:  begin mul_a = 36'(r_coef_a2); mul_b = 36'(r_qoh1); mul_sub = 1'b1; end
            P_MUL_TURN: begin mul_a = dqip_pkg::INV_TWO_PI; mul_b = 36'(r_rho); end
            P_MUL_AC:   begin mul_a = 36'(r_yd); mul_b = 36'(r_cx); end
            P_MUL_AS:   begin mul_a = 36'(r_yq); mul_b = 36'(r_cy); mul_sub = 1'b1; end
            P_MUL_BS:   begin mul_a = 36'(r_yd); mul_b = 36'(r_cy); end
            P_MUL_BC:   begin mul_a = 36'(r_yq); mul_b = 36'(r_cx); end
            P_MUL_ROOT: begin mul_a = dqip_pkg::HALF_SQRT3; mul_b = 36'(r_beta); end
            P_MUL_PA:   begin mul_a = 36'(r_alpha); mul_b = 36'(r_period); end
            P_MUL_PB:   begin mul_a = 36'(r_phb); mul_b = 36'(r_period); end
            P_MUL_PC:   begin mul_a = 36'(r_phc); mul_b = 36'(r_period); end
            default:    ;
        endcase
    end

    // one multiplier bit per cycle, the top bit weighs negative
    always_comb begin
        n_acc = r_acc;
        if (r_mb[0]) begin
            if (mul_sub ^ (r_cnt == 6'(dqip_pkg::MUL_BITS))) begin
                n_acc = r_acc - r_ma;
            end else begin
                n_acc = r_acc + r_ma;
            end
        end
    end

    // one cordic rotation per cycle
    always_comb begin
        cidx = r_cnt[4:0];
        dx   = r_cy >>> cidx;
        dy   = r_cx >>> cidx;
        if (!r_cz[dqip_pkg::CZ_W-1]) begin
            n_cx = r_cx - dx;
            n_cy = r_cy + dy;
            n_cz = r_cz - 33'(dqip_pkg::atan_turn(cidx));
        end else begin
            n_cx = r_cx + dx;
            n_cy = r_cy - dy;
            n_cz = r_cz + 33'(dqip_pkg::atan_turn(cidx));
        end
    end

    // turn fraction and half-plane fold
    always_comb begin
        turn      = r_acc[dqip_pkg::SIG_FRAC+31:dqip_pkg::SIG_FRAC];
        turn_q    = turn + 32'h4000_0000;
        turn_flip = turn_q[31];
        turn_z    = turn_flip ? turn + 32'h8000_0000 : turn;
    end

    // rounding, saturation and divide helpers
    always_comb begin
        n_y    = dqip_pkg::sat32(dqip_pkg::round_shr(r_acc, dqip_pkg::COEF_FRAC));
        half   = -(72'(r_alpha) <<< (dqip_pkg::TRIG_FRAC - 1));
        mag    = r_acc[AW-1] ? -r_acc : r_acc;
        trial  = {1'b0, r_rem} - {1'b0, r_dd};
        div_ge = !trial[dqip_pkg::REM_W];
        if (r_dneg) begin
            if (r_dovf || (r_q > 18'd32768)) begin
                n_duty = 16'sh8000;
            end else begin
                n_duty = 16'(18'd0 - r_q);
            end
        end else begin
            if (r_dovf || (r_q > 18'd32767)) begin
                n_duty = 16'sh7fff;
            end else begin
                n_duty = 16'(r_q);
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= 24'sd109157;
            r_coef_b1 <= 24'sd22104;
            r_coef_b2 <= -24'sd87053;
            r_coef_a1 <= -24'sd3263034;
            r_coef_a2 <= -24'sd931267;
            r_ref     <= 16'sd1800;
            r_offset  <= 16'd1861;
            r_period  <= 16'd30000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dqip_pkg::REG_B0:     r_coef_b0 <= i_cfg_data;
                dqip_pkg::REG_B1:     r_coef_b1 <= i_cfg_data;
                dqip_pkg::REG_B2:     r_coef_b2 <= i_cfg_data;
                dqip_pkg::REG_A1:     r_coef_a1 <= i_cfg_data;
                dqip_pkg::REG_A2:     r_coef_a2 <= i_cfg_data;
                dqip_pkg::REG_REF:    r_ref     <= i_cfg_data[15:0];
                dqip_pkg::REG_OFFSET: r_offset  <= i_cfg_data[15:0];
                dqip_pkg::REG_PERIOD: r_period  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= P_MUL_ID;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_deh0 <= '0; r_deh1 <= '0; r_doh0 <= '0; r_doh1 <= '0;
            r_qeh0 <= '0; r_qeh1 <= '0; r_qoh0 <= '0; r_qoh1 <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_raw_d <= i_raw_direct;
                        r_raw_q <= i_raw_quadrature;
                        r_raw_a <= i_raw_angle;
                        r_acc   <= '0;
                        r_pc    <= P_MUL_ID;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    case (r_pc)
                        P_ID, P_IQ, P_RHO: begin
                            if (r_pc == P_ID) begin
                                r_id <= dqip_pkg::sat32(
                                    dqip_pkg::round_shr(r_acc,
                                        dqip_pkg::GAIN_FRAC - dqip_pkg::SIG_FRAC)
                                    - $signed(72'(r_offset) << dqip_pkg::SIG_FRAC));
                            end else if (r_pc == P_IQ) begin
                                r_iq <= dqip_pkg::sat32(
                                    dqip_pkg::round_shr(r_acc,
                                        dqip_pkg::GAIN_FRAC - dqip_pkg::SIG_FRAC)
                                    - $signed(72'(r_offset) << dqip_pkg::SIG_FRAC));
                            end else begin
                                r_rho <= dqip_pkg::sat32(
                                    dqip_pkg::round_shr(r_acc,
                                        dqip_pkg::GAIN_FRAC - dqip_pkg::SIG_FRAC)
                                    - $signed(72'(r_offset) << dqip_pkg::SIG_FRAC));
                                r_ed <= dqip_pkg::sat32((72'(r_ref) <<< dqip_pkg::SIG_FRAC)
                                                        - 72'(r_id));
                                r_eq <= dqip_pkg::sat32((72'(r_ref) <<< dqip_pkg::SIG_FRAC)
                                                        - 72'(r_iq));
                            end
                            r_acc <= '0;
                            r_pc  <= t_step'(r_pc + 6'd1);
                        end
                        P_YD: begin
                            r_yd   <= n_y;
                            r_deh1 <= r_deh0;
                            r_deh0 <= r_ed;
                            r_doh1 <= r_doh0;
                            r_doh0 <= n_y;
                            r_acc  <= '0;
                            r_pc   <= t_step'(r_pc + 6'd1);
                        end
                        P_YQ: begin
                            r_yq   <= n_y;
                            r_qeh1 <= r_qeh0;
                            r_qeh0 <= r_eq;
                            r_qoh1 <= r_qoh0;
                            r_qoh0 <= n_y;
                            r_acc  <= '0;
                            r_pc   <= t_step'(r_pc + 6'd1);
                        end
                        P_TURN: begin
                            r_flip <= turn_flip;
                            r_cz   <= 33'($signed(turn_z));
                            r_cx   <= dqip_pkg::CORDIC_GAIN;
                            r_cy   <= '0;
                            r_acc  <= '0;
                            r_cnt  <= '0;
                            r_pc   <= t_step'(r_pc + 6'd1);
                        end
                        P_CORDIC: begin
                            // rotations, then undo the half-plane fold
                            if (r_cnt == 6'(dqip_pkg::CORDIC_STEPS)) begin
                                if (r_flip) begin
                                    r_cx <= -r_cx;
                                    r_cy <= -r_cy;
                                end
                                r_cnt <= '0;
                                r_pc  <= t_step'(r_pc + 6'd1);
                            end else begin
                                r_cx  <= n_cx;
                                r_cy  <= n_cy;
                                r_cz  <= n_cz;
                                r_cnt <= r_cnt + 6'd1;
                            end
                        end
                        P_ALPHA, P_BETA: begin
                            if (r_pc == P_ALPHA) begin
                                r_alpha <= dqip_pkg::sat32(
                                    dqip_pkg::round_shr(r_acc, dqip_pkg::TRIG_FRAC));
                            end else begin
                                r_beta <= dqip_pkg::sat32(
                                    dqip_pkg::round_shr(r_acc, dqip_pkg::TRIG_FRAC));
                            end
                            r_acc <= '0;
                            r_pc  <= t_step'(r_pc + 6'd1);
                        end
                        P_ROOT: begin
                            // inverse clarke for phases b and c
                            r_phb <= dqip_pkg::PH_W'(
                                dqip_pkg::round_shr(half + r_acc, dqip_pkg::TRIG_FRAC));
                            r_phc <= dqip_pkg::PH_W'(
                                dqip_pkg::round_shr(half - r_acc, dqip_pkg::TRIG_FRAC));
                            r_acc <= '0;
                            r_pc  <= t_step'(r_pc + 6'd1);
                        end
                        P_DIV_A, P_DIV_B, P_DIV_C: begin
                            // restoring divide of the magnitude, one quotient bit a cycle
                            if (r_cnt == 6'd0) begin
                                r_rem  <= mag[dqip_pkg::REM_W-1:0];
                                r_dneg <= r_acc[AW-1];
                                r_dovf <= (mag >= $signed(72'(dqip_pkg::DUTY_DIV)
                                                   << dqip_pkg::QUOT_BITS));
                                r_dd   <= dqip_pkg::DUTY_DIV << (dqip_pkg::QUOT_BITS - 1);
                                r_q    <= '0;
                                r_cnt  <= r_cnt + 6'd1;
                            end else if (r_cnt == 6'(dqip_pkg::DIV_DONE)) begin
                                if (r_pc == P_DIV_A) begin
                                    r_duty_a <= n_duty;
                                    r_pc     <= t_step'(r_pc + 6'd1);
                                end else if (r_pc == P_DIV_B) begin
                                    r_duty_b <= n_duty;
                                    r_pc     <= t_step'(r_pc + 6'd1);
                                end else begin
                                    r_duty_c <= n_duty;
                                    r_state  <= S_OUT;
                                end
                                r_acc <= '0;
                                r_cnt <= '0;
                            end else begin
                                if (div_ge) begin
                                    r_rem <= trial[dqip_pkg::REM_W-1:0];
                                end
                                r_q   <= {r_q[dqip_pkg::QUOT_BITS-2:0], div_ge};
                                r_dd  <= r_dd >> 1;
                                r_cnt <= r_cnt + 6'd1;
                            end
                        end
                        default: begin
                            // serial multiply-accumulate: load, then one bit a cycle
                            if (r_cnt == 6'd0) begin
                                r_ma   <= 72'(mul_a);
                                r_mb   <= mul_b;
                                r_cnt  <= r_cnt + 6'd1;
                            end else begin
                                r_acc <= n_acc;
                                r_ma  <= r_ma <<< 1;
                                r_mb  <= r_mb >>> 1;
                                if (r_cnt == 6'(dqip_pkg::MUL_BITS)) begin
                                    r_cnt <= '0;
                                    r_pc  <= t_step'(r_pc + 6'd1);
                                end else begin
                                    r_cnt <= r_cnt + 6'd1;
                                end
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    // hand the word over once the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_a     <= r_duty_a;
                        r_out_b     <= r_duty_b;
                        r_out_c     <= r_duty_c;
                        r_out_valid <= 1'b1;
                        r_pc        <= P_MUL_ID;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `DQIP_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall,
        r_state == S_RUN && r_pc == P_MUL_ID && r_cnt == 6'd0,
        "accepted word did not start the sequence")
    `DQIP_ASSERT_NOW(a_mul_count, r_state == S_RUN && r_pc == P_MUL_ID,
        r_cnt <= 6'(dqip_pkg::MUL_BITS), "multiplier count out of range")
    `DQIP_ASSERT_NEXT(a_out_hold, r_state == S_OUT && r_out_valid && i_out_stall,
        r_state == S_OUT, "result left while output register was full")
    `DQIP_ASSERT_NOW(a_cordic_count, r_state == S_RUN && r_pc == P_CORDIC,
        r_cnt <= 6'(dqip_pkg::CORDIC_STEPS), "cordic count out of range")

endmodule

>>> test/tb.sv
// self-checking testbench for the dq current controller with inverse park and clarke
module tb;

    localparam int  CLK_HALF     = 5;
    localparam int  BLOCK_CYCLES = 1000;
    localparam longint RUN_LIMIT = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [dqip_pkg::SAMPLE_BITS-1:0] i_raw_direct;
    logic [dqip_pkg::SAMPLE_BITS-1:0] i_raw_quadrature;
    logic [dqip_pkg::SAMPLE_BITS-1:0] i_raw_angle;
    logic        o_out_valid;
    logic        i_out_stall;
    logic signed [15:0] o_duty_phase_a;
    logic signed [15:0] o_duty_phase_b;
    logic signed [15:0] o_duty_phase_c;
    logic        i_cfg_we;
    logic [dqip_pkg::CFG_IDX_W-1:0]  i_cfg_addr;
    logic [dqip_pkg::CFG_DATA_W-1:0] i_cfg_data;

    typedef struct packed {
        logic signed [15:0] phase_a;
        logic signed [15:0] phase_b;
        logic signed [15:0] phase_c;
    } t_duty_set;

    t_duty_set duty_queue[$];

    // controller copy of configuration and filter history
    logic signed [31:0] ctl_coef[5];
    logic signed [31:0] ctl_reference;
    logic [15:0]        ctl_offset;
    logic [15:0]        ctl_period;
    logic signed [31:0] err_hist[2][2];
    logic signed [31:0] out_hist[2][2];
    longint             atan_step[dqip_pkg::CORDIC_STEPS];

    bit     idle_on;
    int     rx_hold;
    int     mismatches;
    int     words_sent;
    int     words_checked;
    longint cycle_count;

    dq_current_controller_inverse_park u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_direct     (i_raw_direct),
        .i_raw_quadrature (i_raw_quadrature),
        .i_raw_angle      (i_raw_angle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_duty_phase_a   (o_duty_phase_a),
        .o_duty_phase_b   (o_duty_phase_b),
        .o_duty_phase_c   (o_duty_phase_c),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL dq_current_controller_inverse_park");
            $finish;
        end
    end

    // fixed point helpers
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint half_up_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] scaled_current(
        input logic [dqip_pkg::SAMPLE_BITS-1:0] raw);
        longint g;
        g = half_up_shift(longint'(raw) * 64'sd93428374, 16);
        return clamp32(g - (longint'(ctl_offset) <<< 16));
    endfunction

    function automatic logic signed [15:0] duty_of(input longint phase);
        longint d;
        d = (longint'(ctl_period) * phase) / (64'sd100 <<< 16);
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;
        return d[15:0];
    endfunction

    // one biquad step on axis ax, updating its history
    function automatic logic signed [31:0] biquad_step(input int ax,
                                                       input logic signed [31:0] err);
        longint acc;
        logic signed [31:0] y;
        acc = longint'(ctl_coef[0]) * err + longint'(ctl_coef[1]) * err_hist[ax][0]
            + longint'(ctl_coef[2]) * err_hist[ax][1] - longint'(ctl_coef[3]) * out_hist[ax][0]
            - longint'(ctl_coef[4]) * out_hist[ax][1];
        y = clamp32(half_up_shift(acc, 22));
        err_hist[ax][1] = err_hist[ax][0];
        err_hist[ax][0] = err;
        out_hist[ax][1] = out_hist[ax][0];
        out_hist[ax][0] = y;
        return y;
    endfunction

    // full controller: samples in, three duties out
    function automatic t_duty_set predict_duties(input logic [dqip_pkg::SAMPLE_BITS-1:0] rd,
                                                 input logic [dqip_pkg::SAMPLE_BITS-1:0] rq,
                                                 input logic [dqip_pkg::SAMPLE_BITS-1:0] ra);
        longint ref_v, prod, x, y, z, dx, dy, c, s, alpha, beta, half_v, root;
        logic signed [31:0] yd, yq, rho;
        logic [31:0] turn, turn_q;
        bit flip;
        t_duty_set r;
        ref_v = longint'(ctl_reference) <<< 16;
        rho   = scaled_current(ra);
        yd    = biquad_step(0, clamp32(ref_v - scaled_current(rd)));
        yq    = biquad_step(1, clamp32(ref_v - scaled_current(rq)));
        // angle to turn fraction, fold into the right half plane
        prod   = longint'(rho) * 64'sd683565276;
        turn   = prod[47:16];
        turn_q = turn + 32'h4000_0000;
        flip   = turn_q[31];
        if (flip) turn = turn + 32'h8000_0000;
        z = longint'($signed(turn));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < dqip_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_step[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_step[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        alpha  = clamp32(half_up_shift(longint'(yd) * c - longint'(yq) * s, 30));
        beta   = clamp32(half_up_shift(longint'(yd) * s + longint'(yq) * c, 30));
        half_v = -alpha * (64'sd1 <<< 29);
        root   = 64'sd929887697 * beta;
        r.phase_a = duty_of(alpha);
        r.phase_b = duty_of(half_up_shift(half_v + root, 30));
        r.phase_c = duty_of(half_up_shift(half_v - root, 30));
        return r;
    endfunction

    // receiver: stall pattern and result check just ahead of each rising edge
    initial begin
        t_duty_set exp_d;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_stall = 1'b1;
                rx_hold = rx_hold - 1;
            end else begin
                i_out_stall = idle_on && ($urandom_range(99) < 32);
            end
            #(CLK_HALF - 1);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (duty_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: %0d %0d %0d",
                                 o_duty_phase_a, o_duty_phase_b, o_duty_phase_c);
                end else begin
                    exp_d = duty_queue.pop_front();
                    words_checked++;
                    if (exp_d.phase_a !== o_duty_phase_a || exp_d.phase_b !== o_duty_phase_b
                        || exp_d.phase_c !== o_duty_phase_c) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: expected %0d %0d %0d got %0d %0d %0d",
                                     words_checked, exp_d.phase_a, exp_d.phase_b,
                                     exp_d.phase_c, o_duty_phase_a, o_duty_phase_b,
                                     o_duty_phase_c);
                    end
                end
            end
        end
    end

    // send one word, called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [dqip_pkg::SAMPLE_BITS-1:0] rd,
                             input logic [dqip_pkg::SAMPLE_BITS-1:0] rq,
                             input logic [dqip_pkg::SAMPLE_BITS-1:0] ra);
        bit taken;
        taken = 0;
        while (idle_on && ($urandom_range(99) < 32)) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       = 1'b1;
        i_raw_direct     = rd;
        i_raw_quadrature = rq;
        i_raw_angle      = ra;
        while (!taken) begin
            #(CLK_HALF - 1);
            if (!o_in_stall) begin
                taken = 1;
                duty_queue.push_back(predict_duties(rd, rq, ra));
                words_sent++;
            end
            @(negedge i_clk);
        end
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            send_word($urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (duty_queue.size() != 0) @(negedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [dqip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dqip_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (BLOCK_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        if (idx == dqip_pkg::REG_REF) ctl_reference = $signed(val[15:0]);
        else if (idx == dqip_pkg::REG_OFFSET) ctl_offset = val[15:0];
        else if (idx == dqip_pkg::REG_PERIOD) ctl_period = val[15:0];
        else ctl_coef[idx] = $signed(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_defaults();
        write_reg(dqip_pkg::REG_B0, 24'd109157);
        write_reg(dqip_pkg::REG_B1, 24'd22104);
        write_reg(dqip_pkg::REG_B2, -24'sd87053);
        write_reg(dqip_pkg::REG_A1, -24'sd3263034);
        write_reg(dqip_pkg::REG_A2, -24'sd931267);
        write_reg(dqip_pkg::REG_REF, 24'd1800);
        write_reg(dqip_pkg::REG_OFFSET, 24'd1861);
        write_reg(dqip_pkg::REG_PERIOD, 24'd30000);
    endtask

    // sample extremes and angle sweep at reset settings
    task automatic test_sample_extremes();
        send_word(12'd0, 12'd0, 12'd0);
        send_word(12'd4095, 12'd4095, 12'd4095);
        send_word(12'd0, 12'd4095, 12'd2048);
        send_word(12'd4095, 12'd0, 12'd1);
        send_word(12'hAAA, 12'h555, 12'hAAA);
        send_word(12'h555, 12'hAAA, 12'h555);
        for (int k = 0; k < 8; k++)
            send_word(12'd1000 + 12'(k * 7), 12'd3000 - 12'(k * 11), 12'(k * 512));
    endtask

    // register extremes: saturation, zero offset, period limits
    task automatic test_register_extremes();
        write_reg(dqip_pkg::REG_B0, 24'h7fffff);
        write_reg(dqip_pkg::REG_B1, 24'h800000);
        write_reg(dqip_pkg::REG_B2, 24'h7fffff);
        write_reg(dqip_pkg::REG_A1, 24'h800000);
        write_reg(dqip_pkg::REG_A2, 24'h7fffff);
        write_reg(dqip_pkg::REG_REF, 24'h007fff);
        write_reg(dqip_pkg::REG_OFFSET, 24'd0);
        write_reg(dqip_pkg::REG_PERIOD, 24'd65535);
        send_word(12'd0, 12'd4095, 12'd100);
        send_word(12'd4095, 12'd0, 12'd3000);
        send_word(12'd2000, 12'd2000, 12'd4095);
        write_reg(dqip_pkg::REG_REF, 24'h008000);
        write_reg(dqip_pkg::REG_OFFSET, 24'd65535);
        write_reg(dqip_pkg::REG_PERIOD, 24'd1);
        send_word(12'd4095, 12'd4095, 12'd0);
        send_word(12'd0, 12'd0, 12'd4095);
        write_reg(dqip_pkg::REG_PERIOD, 24'd0);
        send_word(12'd1234, 12'd3210, 12'd777);
    endtask

    // random samples at reset settings, part with no idling
    task automatic test_random_default();
        load_defaults();
        send_random(120);
        idle_on = 0;
        send_random(100);
        idle_on = 1;
    endtask

    // random register sets, mostly mild coefficients, one wild set
    task automatic test_random_settings();
        for (int set_i = 0; set_i < 4; set_i++) begin
            if (set_i == 3) begin
                for (int r = 0; r < 5; r++)
                    write_reg(dqip_pkg::REG_B0 + 3'(r), 24'($urandom));
            end else begin
                for (int r = 0; r < 3; r++)
                    write_reg(dqip_pkg::REG_B0 + 3'(r),
                              24'($signed($urandom_range(400000)) - 200000));
                write_reg(dqip_pkg::REG_A1, 24'($signed($urandom_range(1000000)) - 500000));
                write_reg(dqip_pkg::REG_A2, 24'($signed($urandom_range(400000)) - 200000));
            end
            write_reg(dqip_pkg::REG_REF, 24'($urandom_range(65535)));
            write_reg(dqip_pkg::REG_OFFSET, 24'($urandom_range(3000)));
            write_reg(dqip_pkg::REG_PERIOD, 24'($urandom_range(65535, 1)));
            send_random(90);
        end
    endtask

    // receiver holds off long enough to stall the input, then a full pause
    task automatic test_backpressure();
        load_defaults();
        rx_hold = 3000;
        send_random(6);
        wait_drained();
        send_random(15);
        wait_drained();
        send_random(80);
    endtask

    initial begin
        foreach (atan_step[i]) atan_step[i] = longint'(dqip_pkg::atan_turn(5'(i)));
        ctl_coef[0] = 109157;
        ctl_coef[1] = 22104;
        ctl_coef[2] = -87053;
        ctl_coef[3] = -3263034;
        ctl_coef[4] = -931267;
        ctl_reference = 1800;
        ctl_offset    = 1861;
        ctl_period    = 30000;
        foreach (err_hist[a, b]) begin
            err_hist[a][b] = 0;
            out_hist[a][b] = 0;
        end
        idle_on = 1; rx_hold = 0; mismatches = 0;
        words_sent = 0; words_checked = 0; cycle_count = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0;
        i_raw_direct = '0; i_raw_quadrature = '0; i_raw_angle = '0;
        i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_sample_extremes();
        test_register_extremes();
        test_random_default();
        test_random_settings();
        test_backpressure();
        wait_drained();
        repeat (BLOCK_CYCLES) @(negedge i_clk);
        $display("sent %0d words, checked %0d results, %0d mismatches", words_sent,
                 words_checked, mismatches);
        $display("covered sample and register extremes, random settings and output hold-off");
        if (mismatches == 0 && duty_queue.size() == 0) begin
            $display("PASS dq_current_controller_inverse_park");
        end else begin
            $display("FAIL dq_current_controller_inverse_park");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/dqip_pkg.sv
sv/dq_current_controller_inverse_park.sv
test/tb.sv
